>>> hdl/sitoa_pkg.sv
package sitoa_pkg;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [3:0] BCD_ADJUST_MIN = 4'd5;
  localparam logic [3:0] BCD_ADJUST     = 4'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_DIGIT
  } sitoa_state_e;

  typedef struct packed {
    logic load;
    logic conv_step;
    logic digit_shift;
    logic show_sign;
  } sitoa_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic top_zero;
    logic rem_one;
    logic negative;
  } sitoa_sts_t;

endpackage

>>> hdl/sitoa_if.sv
interface sitoa_in_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface sitoa_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink (input valid, input character, input last, output ready);
endinterface

>>> hdl/signed_int_to_decimal_ascii.sv
// Converts a two's complement integer to its decimal text, one ASCII character
// per output transfer, most significant character first.
// The input channel carries one VALUE_WIDTH-bit value per transfer. The output
// channel carries one character per transfer: a leading '-' for a negative
// value, then the digits without leading zeros; last marks the final digit.
// Zero gives the single character '0'.
// Conversion is a bit-serial double dabble loop, one input bit per cycle.
// Leading zero digits are then dropped one per cycle, up to NDIG-1 of them
// (9 at 32 bits), where NDIG is the digit capacity of the BCD register (10 at
// 32 bits), and then the first digit is found. The text then goes out one
// character per cycle while the receiver is ready, up to 11 characters at 32
// bits. Dropped and emitted digits always add up to NDIG. The next value is
// taken in the same cycle as the transfer of the last character; when none is
// waiting the block goes idle. When the receiver stalls, the current character
// holds and no new value is taken. Reset returns the controller to idle, ready
// for a value, and drops any conversion in progress.
module signed_int_to_decimal_ascii #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sitoa_in_if.sink    in_i,
  sitoa_out_if.source out_o
);
  import sitoa_pkg::*;

  sitoa_cmd_t cmd;
  sitoa_sts_t sts;

  sitoa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sitoa_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (in_i.value),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .character_o (out_o.character),
    .last_o      (out_o.last)
  );

  a_accept_only_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && in_i.ready) |-> out_o.last)
    else $error("input taken while text of the previous value is unfinished");

  a_no_output_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !out_o.valid)
    else $error("character offered before conversion ran");

  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.character == CHAR_MINUS) |-> !out_o.last)
    else $error("minus sign flagged as last character");

  a_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.character == CHAR_MINUS ||
                     (out_o.character >= CHAR_ZERO && out_o.character <= CHAR_NINE)))
    else $error("character is neither a digit nor a minus sign");

endmodule

>>> hdl/sitoa_ctrl.sv
module sitoa_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  sitoa_pkg::sitoa_sts_t sts_i,
  output sitoa_pkg::sitoa_cmd_t cmd_o
);
  import sitoa_pkg::*;

  sitoa_state_e state_q, state_d;
  logic         skip_more;

  assign skip_more = sts_i.top_zero && !sts_i.rem_one;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        if (sts_i.conv_done) begin
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (!skip_more) begin
          state_d = sts_i.negative ? ST_SIGN : ST_DIGIT;
        end
      end
      ST_SIGN: begin
        if (out_ready_i) begin
          state_d = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (out_ready_i && sts_i.rem_one) begin
          state_d = in_valid_i ? ST_CONV : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o        = 1'b0;
    out_valid_o       = 1'b0;
    cmd_o.conv_step   = 1'b0;
    cmd_o.digit_shift = 1'b0;
    cmd_o.show_sign   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ST_CONV: begin
        cmd_o.conv_step = 1'b1;
      end
      ST_SKIP: begin
        cmd_o.digit_shift = skip_more;
      end
      ST_SIGN: begin
        out_valid_o     = 1'b1;
        cmd_o.show_sign = 1'b1;
      end
      ST_DIGIT: begin
        out_valid_o       = 1'b1;
        in_ready_o        = out_ready_i && sts_i.rem_one;
        cmd_o.digit_shift = out_ready_i && !sts_i.rem_one;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
    cmd_o.load = in_valid_i && in_ready_o;
  end

endmodule

>>> hdl/sitoa_dp.sv
module sitoa_dp #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  input  sitoa_pkg::sitoa_cmd_t         cmd_i,
  output sitoa_pkg::sitoa_sts_t         sts_o,
  output logic [7:0]                    character_o,
  output logic                          last_o
);
  import sitoa_pkg::*;

  localparam int NDIG = (VALUE_WIDTH * 302) / 1000 + 1;
  localparam int BCDW = 4 * NDIG;
  localparam int CW   = $clog2(VALUE_WIDTH + 1);
  localparam int RW   = $clog2(NDIG + 1);

  logic [VALUE_WIDTH-1:0] mag_q, mag_d;
  logic [BCDW-1:0]        bcd_q, bcd_d;
  logic                   neg_q, neg_d;
  logic [CW-1:0]          bitcnt_q, bitcnt_d;
  logic [RW-1:0]          rem_q, rem_d;
  logic [BCDW-1:0]        bcd_adj;
  logic [VALUE_WIDTH-1:0] raw;
  logic [3:0]             top_digit;

  assign raw       = value_i;
  assign top_digit = bcd_q[BCDW-1 -: 4];

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= BCD_ADJUST_MIN) ?
                          bcd_q[4*i +: 4] + BCD_ADJUST : bcd_q[4*i +: 4];
    end
  end

  always_comb begin
    mag_d    = mag_q;
    bcd_d    = bcd_q;
    neg_d    = neg_q;
    bitcnt_d = bitcnt_q;
    rem_d    = rem_q;
    if (cmd_i.load) begin
      neg_d    = raw[VALUE_WIDTH-1];
      mag_d    = raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;
      bcd_d    = '0;
      bitcnt_d = CW'(VALUE_WIDTH);
      rem_d    = RW'(NDIG);
    end else if (cmd_i.conv_step) begin
      bcd_d    = {bcd_adj[BCDW-2:0], mag_q[VALUE_WIDTH-1]};
      mag_d    = {mag_q[VALUE_WIDTH-2:0], 1'b0};
      bitcnt_d = bitcnt_q - 1'b1;
    end else if (cmd_i.digit_shift) begin
      bcd_d = {bcd_q[BCDW-5:0], 4'd0};
      rem_d = rem_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bitcnt_q <= '0;
      rem_q    <= '0;
    end else begin
      bitcnt_q <= bitcnt_d;
      rem_q    <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    bcd_q <= bcd_d;
    neg_q <= neg_d;
  end

  assign sts_o.conv_done = (bitcnt_q == CW'(1));
  assign sts_o.top_zero  = (top_digit == 4'd0);
  assign sts_o.rem_one   = (rem_q == RW'(1));
  assign sts_o.negative  = neg_q;

  assign character_o = cmd_i.show_sign ? CHAR_MINUS : (CHAR_ZERO | {4'd0, top_digit});
  assign last_o      = !cmd_i.show_sign && sts_o.rem_one;

endmodule

>>> dv/sitoa_text_checker.sv
module sitoa_text_checker #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  logic [VALUE_WIDTH-1:0] in_value_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  logic [7:0]             out_character_i,
  input  logic                   out_last_i,
  output int                     mismatch_count_o,
  output int                     pending_chars_o,
  output int                     checked_chars_o
);

  timeunit 1ns;
  timeprecision 1ps;

  import sitoa_pkg::*;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } text_char_t;

  text_char_t expected_text[$];
  text_char_t oldest_char;
  int         mismatches = 0;
  int         checked = 0;

  // Appends the decimal text of one value to the expected characters.
  function automatic void spell_decimal(input logic [VALUE_WIDTH-1:0] value);
    logic [63:0] magnitude;
    logic [3:0]  digits[20];
    int          num_digits;
    text_char_t  ch;
    magnitude = '0;
    if (value[VALUE_WIDTH-1]) begin
      magnitude[VALUE_WIDTH-1:0] = -value;
    end else begin
      magnitude[VALUE_WIDTH-1:0] = value;
    end
    num_digits = 0;
    while (magnitude != 0) begin
      digits[num_digits] = 4'(magnitude % 10);
      magnitude = magnitude / 10;
      num_digits++;
    end
    if (num_digits == 0) begin
      digits[0] = 4'd0;
      num_digits = 1;
    end
    if (value[VALUE_WIDTH-1]) begin
      ch.character = CHAR_MINUS;
      ch.last = 1'b0;
      expected_text.push_back(ch);
    end
    for (int i = num_digits - 1; i >= 0; i--) begin
      ch.character = CHAR_ZERO + 8'(digits[i]);
      ch.last = (i == 0);
      expected_text.push_back(ch);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_text.delete();
      pending_chars_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_text.size() == 0) begin
          $error("Unexpected character transfer: character %h, last %b",
                 out_character_i, out_last_i);
          mismatches++;
        end else begin
          oldest_char = expected_text.pop_front();
          checked++;
          if (out_character_i !== oldest_char.character) begin
            $error("character mismatch: expected %h, actual %h",
                   oldest_char.character, out_character_i);
            mismatches++;
          end
          if (out_last_i !== oldest_char.last) begin
            $error("last mismatch: expected %b, actual %b", oldest_char.last, out_last_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        spell_decimal(in_value_i);
      end
      pending_chars_o <= expected_text.size();
      mismatch_count_o <= mismatches;
      checked_chars_o <= checked;
    end
  end

endmodule

>>> dv/tb_signed_int_to_decimal_ascii.sv
module tb_signed_int_to_decimal_ascii;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int VW = 32;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 100;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic source_gaps = 1'b0;
  logic sink_stalls = 1'b0;
  int   mismatch_count;
  int   pending_chars;
  int   checked_chars;
  int   items_sent = 0;
  int   negatives_sent = 0;
  int   zeros_sent = 0;
  int   quiet_cycles = 0;

  sitoa_in_if #(.VALUE_WIDTH(VW)) in_ch ();
  sitoa_out_if out_ch ();

  signed_int_to_decimal_ascii #(
    .VALUE_WIDTH(VW)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  sitoa_text_checker #(
    .VALUE_WIDTH(VW)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_ch.valid),
    .in_ready_i      (in_ch.ready),
    .in_value_i      (in_ch.value),
    .out_valid_i     (out_ch.valid),
    .out_ready_i     (out_ch.ready),
    .out_character_i (out_ch.character),
    .out_last_i      (out_ch.last),
    .mismatch_count_o(mismatch_count),
    .pending_chars_o (pending_chars),
    .checked_chars_o (checked_chars)
  );

  always #5 clk_i = ~clk_i;

  function automatic int idle_span();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(10, 60);
    end
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [VW-1:0] pick_value();
    longint lo;
    longint hi;
    longint mag;
    longint top_pos;
    int     n;
    top_pos = (longint'(1) << (VW - 1)) - 1;
    n = $urandom_range(1, 10);
    lo = 1;
    repeat (n - 1) lo *= 10;
    hi = lo * 10 - 1;
    if (hi > top_pos) begin
      hi = top_pos;
    end
    case ($urandom_range(0, 4))
      0: return VW'($urandom);
      1: mag = lo + longint'($urandom_range(0, 32'(hi - lo)));
      2: mag = lo + longint'($urandom_range(0, 2)) - 1;
      3: mag = longint'($urandom_range(0, 99));
      default: begin
        if ($urandom_range(0, 1) == 1) begin
          return VW'(-top_pos - 1 + longint'($urandom_range(0, 3)));
        end
        return VW'(top_pos - longint'($urandom_range(0, 3)));
      end
    endcase
    if ($urandom_range(0, 1) == 1) begin
      mag = -mag;
    end
    return VW'(mag);
  endfunction

  task automatic send_value(input logic [VW-1:0] value);
    if (source_gaps && $urandom_range(0, 2) == 0) begin
      in_ch.valid <= 1'b0;
      repeat (idle_span()) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= value;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    items_sent++;
    if (value[VW-1]) negatives_sent++;
    if (value == '0) zeros_sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_chars != 0) @(posedge clk_i);
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (sink_stalls && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat (idle_span()) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("Watchdog expired after %0d cycles without a transfer.", QUIET_LIMIT);
        $display("FAIL signed_int_to_decimal_ascii");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    logic [VW-1:0] directed[$];
    directed = '{
      32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10, 32'sd99,
      32'sd100, 32'sd2147483647, 32'h8000_0000, -32'sd2147483647,
      32'sd1000000000, -32'sd1000000000, 32'sd999999999, 32'sd1234567890,
      -32'sd987654321, 32'h4000_0000, 32'sd1000000, 32'sd5
    };
    rst_ni <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.value <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_value(directed[i]);
    drain();

    source_gaps = 1'b1;
    sink_stalls = 1'b1;
    repeat (90) send_value(pick_value());

    source_gaps = 1'b0;
    sink_stalls = 1'b0;
    repeat (60) send_value(pick_value());
    drain();

    source_gaps = 1'b1;
    sink_stalls = 1'b1;
    repeat (100) send_value(pick_value());

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Converted %0d values (%0d negative, %0d zero); %0d characters checked.",
             items_sent, negatives_sent, zeros_sent, checked_chars);
    if (mismatch_count == 0 && pending_chars == 0) begin
      $display("PASS signed_int_to_decimal_ascii");
    end else begin
      $display("FAIL signed_int_to_decimal_ascii");
    end
    $finish;
  end

endmodule
